// ----- hdl/brsc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brsc_pkg: shared types and constants of the bounded range subarray counter
// Holds the channel payload structs and the link that runs between cells.
// ----------------------------------------------------------------------------
package brsc_pkg;

  localparam int VALUE_W  = 32;
  localparam int SPREAD_W = 32;
  localparam int TOTAL_W  = 19;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] run_count;
    logic               overflow;
  } out_item_t;

  // Item as it travels down the chain. placed is set once the item has
  // opened its own start in the first free cell.
  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic                      placed;
    logic signed [VALUE_W-1:0] value;
    logic [SPREAD_W-1:0]       spread;
  } cell_link_t;

endpackage : brsc_pkg
`default_nettype wire

// ----- hdl/brsc_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brsc_cell: one start position of the counter chain
// Holds the running minimum and maximum of one start, folds each passing
// item into them and hands the item with its partial count to the next cell.
// ----------------------------------------------------------------------------
module brsc_cell
  import brsc_pkg::*;
#(
  parameter int CNT_W = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv_i,
  input  wire cell_link_t       link_i,
  input  wire logic [CNT_W-1:0] cnt_i,
  output cell_link_t            link_o,
  output logic [CNT_W-1:0]      cnt_o
);

  cell_link_t                link_r, link_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      occ_r, occ_nxt;
  logic                      ok_r, ok_nxt;
  logic signed [VALUE_W-1:0] min_r, min_nxt;
  logic signed [VALUE_W-1:0] max_r, max_nxt;
  logic signed [VALUE_W-1:0] lo, hi;
  logic [VALUE_W:0]          diff;

  always_comb begin
    lo   = (link_i.value < min_r) ? link_i.value : min_r;
    hi   = (link_i.value > max_r) ? link_i.value : max_r;
    // exact max - min, never negative, fits in VALUE_W+1 bits
    diff = {hi[VALUE_W-1], hi} - {lo[VALUE_W-1], lo};
  end

  always_comb begin
    link_nxt = link_i;
    cnt_nxt  = cnt_i;
    occ_nxt  = occ_r;
    ok_nxt   = ok_r;
    min_nxt  = min_r;
    max_nxt  = max_r;
    if (link_i.valid && !link_i.placed) begin
      if (!occ_r) begin
        // first free cell: open the start of this item
        occ_nxt         = 1'b1;
        ok_nxt          = 1'b1;
        min_nxt         = link_i.value;
        max_nxt         = link_i.value;
        link_nxt.placed = 1'b1;
      end else if (ok_r) begin
        min_nxt = lo;
        max_nxt = hi;
        if (diff > {1'b0, link_i.spread}) begin
          ok_nxt = 1'b0;
        end else begin
          cnt_nxt = cnt_i + CNT_W'(1);
        end
      end
    end
    // the closing item of a sequence empties the cell behind it
    if (link_i.valid && link_i.last) begin
      occ_nxt = 1'b0;
      ok_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.valid <= 1'b0;
      occ_r        <= 1'b0;
      ok_r         <= 1'b0;
    end else if (adv_i) begin
      link_r <= link_nxt;
      occ_r  <= occ_nxt;
      ok_r   <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      cnt_r <= cnt_nxt;
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  assign link_o = link_r;
  assign cnt_o  = cnt_r;

  a_ok_implies_occ : assert property (@(posedge clk) disable iff (!rst_n)
    ok_r |-> occ_r)
    else $error("brsc_cell: valid start in an empty cell");

  a_min_le_max : assert property (@(posedge clk) disable iff (!rst_n)
    ok_r |-> (min_r <= max_r))
    else $error("brsc_cell: start minimum above maximum");

endmodule : brsc_cell
`default_nettype wire

// ----- hdl/brsc_tail.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brsc_tail: end of the counter chain
// Adds each item's count to the sequence total, flags items that found no
// free cell and holds the result in the output register.
// ----------------------------------------------------------------------------
module brsc_tail
  import brsc_pkg::*;
#(
  parameter int CNT_W = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_link_t       link_i,
  input  wire logic [CNT_W-1:0] cnt_i,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output out_item_t             out_data,
  output logic                  adv_o
);

  localparam int SUM_W = TOTAL_W + 1;

  logic [TOTAL_W-1:0] acc_r, acc_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic [CNT_W-1:0]   add;
  logic [SUM_W-1:0]   sum;
  logic [TOTAL_W-1:0] total_sat;
  logic               take;

  // hold the chain only when a closing item meets a full, stalled output
  assign adv_o = !(link_i.valid && link_i.last && out_valid_r && !out_ready);
  assign take  = adv_o && link_i.valid;

  always_comb begin
    // an item with no cell of its own adds nothing
    add       = link_i.placed ? cnt_i : '0;
    sum       = {1'b0, acc_r} + SUM_W'(add);
    total_sat = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
  end

  always_comb begin
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (take) begin
      if (link_i.last) begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.run_count = total_sat;
        out_data_nxt.overflow  = ovf_r || !link_i.placed;
        acc_nxt                = '0;
        ovf_nxt                = 1'b0;
      end else begin
        acc_nxt = total_sat;
        ovf_nxt = ovf_r || !link_i.placed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_total_grows : assert property (@(posedge clk) disable iff (!rst_n)
    (take && !link_i.last) |=> (acc_r >= $past(acc_r)))
    else $error("brsc_tail: running total decreased within a sequence");

  a_total_cleared : assert property (@(posedge clk) disable iff (!rst_n)
    (take && link_i.last) |=> (acc_r == '0 && !ovf_r && out_valid_r))
    else $error("brsc_tail: sequence end did not clear the total");

endmodule : brsc_tail
`default_nettype wire

// ----- hdl/bounded_range_subarray_counter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_range_subarray_counter: counts runs whose max - min fits a limit
//
// Input channel (in_valid/in_ready/in_data) takes one signed value per
// transfer; in_data.last marks the final value of a sequence. For each
// sequence the block counts the contiguous runs of two or more values whose
// largest minus smallest value is at most cfg max_spread, and returns one
// result on the output channel (out_valid/out_ready/out_data) after the
// marked value. out_data.overflow reports a sequence longer than LENGTH;
// the extra values are neither stored nor counted.
//
// Values travel down a chain of LENGTH cells, each holding one start
// position. While the chain moves, values advance one cell per cycle and
// throughput is one transfer per cycle; the result is registered once the
// marked value has walked the full chain. Each item carries the max_spread
// in force when it was taken, so a write applies from the next value on.
//
// Reset (rst_n low, synchronous) empties every cell, clears the total and
// sets max_spread to zero. While a result waits on a stalled receiver the
// chain keeps moving until the next marked value reaches its end; then the
// whole chain and in_ready hold until the output register is freed.
// ----------------------------------------------------------------------------
module bounded_range_subarray_counter
  import brsc_pkg::*;
#(
  parameter int LENGTH = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_item_t                out_data,
  input  wire logic                cfg_we,
  input  wire logic [SPREAD_W-1:0] cfg_wdata
);

  // a placed item passes at most LENGTH-1 occupied cells
  localparam int CW = (LENGTH > 2) ? $clog2(LENGTH) : 1;

  logic [SPREAD_W-1:0] spread_r;
  logic                adv;
  cell_link_t          head_link;
  cell_link_t          link_w [LENGTH+1];
  logic [CW-1:0]       cnt_w  [LENGTH+1];

  // configuration register, written without wait state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spread_r <= '0;
    end else if (cfg_we) begin
      spread_r <= cfg_wdata;
    end
  end

  // new item enters cell 0 unplaced with an empty count
  always_comb begin
    head_link.valid  = in_valid;
    head_link.last   = in_data.last;
    head_link.placed = 1'b0;
    head_link.value  = in_data.value;
    head_link.spread = spread_r;
  end

  assign link_w[0] = head_link;
  assign cnt_w[0]  = '0;

  for (genvar k = 0; k < LENGTH; k++) begin : g_chain
    brsc_cell #(
      .CNT_W (CW)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv_i  (adv),
      .link_i (link_w[k]),
      .cnt_i  (cnt_w[k]),
      .link_o (link_w[k+1]),
      .cnt_o  (cnt_w[k+1])
    );
  end

  // accumulate counts and drive the result register
  brsc_tail #(
    .CNT_W (CW)
  ) u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .link_i    (link_w[LENGTH]),
    .cnt_i     (cnt_w[LENGTH]),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .adv_o     (adv)
  );

  // the whole chain moves together; take input whenever it moves
  assign in_ready = adv;

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("bounded_range_subarray_counter: input held without output stall");

endmodule : bounded_range_subarray_counter
`default_nettype wire

// ----- bench/brsc_run_checker.sv -----
// ----------------------------------------------------------------------------
// brsc_run_checker: scoreboard for the bounded range subarray counter
// Mirrors every accepted value into a start table of its own, predicts the
// run count and overflow flag of each marked sequence and compares them,
// field by field and in order, with the transfers on the result channel.
// ----------------------------------------------------------------------------
module brsc_run_checker
  import brsc_pkg::*;
#(
  parameter int LENGTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [SPREAD_W-1:0] cfg_wdata,
  output int                  mismatches,
  output int                  tallies_pending,
  output int                  tallies_checked,
  output int                  overflow_tallies
);

  localparam longint TALLY_MAX  = (64'sd1 <<< TOTAL_W) - 1;

  logic [SPREAD_W-1:0] spread_limit;
  longint              start_lo   [LENGTH];
  longint              start_hi   [LENGTH];
  bit                  start_live [LENGTH];
  int                  starts_open;
  longint              pair_total;
  bit                  too_long;
  out_item_t           expected_tallies [$];
  out_item_t           tally;

  function automatic void clear_starts();
    for (int j = 0; j < LENGTH; j++) start_live[j] = 1'b0;
    starts_open = 0;
    pair_total  = 0;
    too_long    = 1'b0;
  endfunction

  // Fold one value into every live start, count the survivors, then open a
  // start at the value itself. Values past LENGTH only flag the overflow.
  function automatic void fold_value(longint v);
    longint added;
    added = 0;
    if (starts_open >= LENGTH) begin
      too_long = 1'b1;
      return;
    end
    for (int j = 0; j < starts_open; j++) begin
      if (start_live[j]) begin
        if (v < start_lo[j]) start_lo[j] = v;
        if (v > start_hi[j]) start_hi[j] = v;
        if (start_hi[j] - start_lo[j] > longint'(spread_limit)) start_live[j] = 1'b0;
        else added++;
      end
    end
    pair_total = (pair_total + added > TALLY_MAX) ? TALLY_MAX : pair_total + added;
    start_lo[starts_open]   = v;
    start_hi[starts_open]   = v;
    start_live[starts_open] = 1'b1;
    starts_open++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      spread_limit = '0;
      clear_starts();
    end else begin
      if (in_valid && in_ready) begin
        fold_value(longint'($signed(in_data.value)));
        if (in_data.last) begin
          tally.run_count = pair_total[TOTAL_W-1:0];
          tally.overflow  = too_long;
          expected_tallies.push_back(tally);
          clear_starts();
        end
      end
      if (cfg_we) spread_limit = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_tallies.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual run_count %0d overflow %0b",
                   $time, out_data.run_count, out_data.overflow);
        end else begin
          tally = expected_tallies.pop_front();
          tallies_checked++;
          if (tally.overflow) overflow_tallies++;
          if (out_data.run_count !== tally.run_count) begin
            mismatches++;
            $display("%0t: run_count mismatch, expected %0d, actual %0d",
                     $time, tally.run_count, out_data.run_count);
          end
          if (out_data.overflow !== tally.overflow) begin
            mismatches++;
            $display("%0t: overflow mismatch, expected %0b, actual %0b",
                     $time, tally.overflow, out_data.overflow);
          end
        end
      end
    end
    tallies_pending = expected_tallies.size();
  end

endmodule : brsc_run_checker

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench top of the bounded range subarray counter
// Drives signed values in marked sequences under a range of max_spread
// settings, with random idle cycles on both channels and a long receiver
// stall. The run checker beside the block predicts and compares every
// result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb
  import brsc_pkg::*;
();

  localparam int LENGTH         = 1024;
  localparam int GAP_MAX        = 16;
  // Long enough that two marked values reach the end of the chain while the
  // receiver is away, so the block must drop in_ready.
  localparam int HOLD_CYCLES    = 3000;
  // A value walks LENGTH cells before its result shows up.
  localparam int SETTLE_CYCLES  = LENGTH + 24;
  localparam int WATCHDOG_LIMIT = 4 * (HOLD_CYCLES + 2 * LENGTH);

  localparam logic signed [VALUE_W-1:0] VALUE_FLOOR = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_CEIL  = 32'sh7FFF_FFFF;

  // How the values of one sequence are picked.
  typedef enum int {
    VAL_WIDE,   // any 32-bit value
    VAL_NEAR,   // a base plus offsets that straddle the spread limit
    VAL_FLAT,   // one value repeated
    VAL_EDGE    // the two extremes of the value range
  } value_style_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_we;
  logic [SPREAD_W-1:0] cfg_wdata;

  int                  mismatches;
  int                  tallies_pending;
  int                  tallies_checked;
  int                  overflow_tallies;

  int                  values_sent;
  int                  sequences_sent;
  int                  spread_writes;
  int                  quiet_cycles;
  int                  tx_calm;
  int                  rx_calm;
  bit                  offering;
  bit                  hold_request;
  logic [SPREAD_W-1:0] spread_now;

  bounded_range_subarray_counter #(
    .LENGTH(LENGTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  brsc_run_checker #(
    .LENGTH(LENGTH)
  ) run_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .tallies_pending (tallies_pending),
    .tallies_checked (tallies_checked),
    .overflow_tallies(overflow_tallies)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Draw the idle cycles before the next transfer. Now and then start a calm
  // stretch in which the side never idles.
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, GAP_MAX);
  endfunction

  // Drop valid, but only if it is up, so that no step sees two drives of it.
  task automatic stop_offering();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Offer one value after a random gap and hold it until the transfer.
  task automatic send_value(input logic signed [VALUE_W-1:0] v, input logic mark);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      stop_offering();
      repeat (gap) @(posedge clk);
    end
    in_data  <= in_item_t'({v, mark});
    in_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    values_sent++;
  endtask

  task automatic send_sequence(input int len, input value_style_t style);
    logic signed [VALUE_W-1:0] base;
    logic signed [VALUE_W-1:0] v;
    logic [SPREAD_W-1:0]       reach;
    base = $urandom;
    // Spread the offsets over about twice the limit so that roughly half of
    // the runs fit; near the top of the range use every offset.
    if (spread_now >= 32'h7FFF_FFFF) reach = '1;
    else reach = spread_now * 2 + 1;
    for (int k = 0; k < len; k++) begin
      case (style)
        VAL_WIDE: v = $urandom;
        VAL_NEAR: v = base + $urandom_range(0, reach);
        VAL_FLAT: v = base;
        default:  v = $urandom_range(0, 1) ? VALUE_CEIL : VALUE_FLOOR;
      endcase
      send_value(v, k == len - 1);
    end
    sequences_sent++;
  endtask

  // Pause until every result is back and the chain has emptied, then write
  // max_spread. The block is idle for the whole write.
  task automatic set_spread(input logic [SPREAD_W-1:0] spread);
    stop_offering();
    do @(posedge clk); while (tallies_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wdata <= spread;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    spread_now = spread;
    spread_writes++;
  endtask

  // One random phase: mostly short sequences, a few longer ones, and a mix
  // of value styles, until the budget of values is used up.
  task automatic run_phase(input logic [SPREAD_W-1:0] spread, input int budget,
                           input bit squeeze);
    int           stop_at;
    int           len;
    value_style_t style;
    set_spread(spread);
    // Ask the receiver for its long stall while this phase keeps sending.
    if (squeeze) hold_request = 1'b1;
    stop_at = values_sent + budget;
    while (values_sent < stop_at) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0:       style = VAL_FLAT;
        1:       style = VAL_EDGE;
        2, 3:    style = VAL_WIDE;
        default: style = VAL_NEAR;
      endcase
      send_sequence(len, style);
    end
  endtask

  // Receiver: idle a random number of cycles before each result, once hold
  // off for a long stretch, then take the result.
  initial begin : receiver
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = pick_gap(rx_calm);
      if (hold_request && !hold_done) begin
        gap       = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Watchdog: end the run if nothing is transferred for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    offering     = 1'b0;
    hold_request = 1'b0;
    spread_now   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset spread of zero: equal neighbors count, a single value counts
    // nothing, and the two extremes never pair up.
    send_value(32'sd5, 1'b0);
    send_value(32'sd5, 1'b0);
    send_value(32'sd5, 1'b1);
    send_value(-32'sd7, 1'b1);
    send_value(VALUE_FLOOR, 1'b0);
    send_value(VALUE_CEIL, 1'b1);

    // Widest spread: even the full value range fits, so every run counts.
    set_spread('1);
    send_value(VALUE_FLOOR, 1'b0);
    send_value(VALUE_CEIL, 1'b0);
    send_value(32'sd0, 1'b0);
    send_value(-32'sd1, 1'b1);

    // One below the widest: the full range fails by one, one less fits.
    set_spread(32'hFFFF_FFFE);
    send_value(VALUE_CEIL, 1'b0);
    send_value(VALUE_FLOOR, 1'b1);
    send_value(VALUE_CEIL, 1'b0);
    send_value(VALUE_FLOOR + 1, 1'b0);
    send_value(32'sd0, 1'b1);

    // Small limit: a start that overshoots stays dead while later ones live.
    set_spread(32'd3);
    send_value(32'sd0, 1'b0);
    send_value(32'sd4, 1'b0);
    send_value(32'sd2, 1'b0);
    send_value(32'sd2, 1'b0);
    send_value(32'sd5, 1'b1);

    // Random phases over a spread of settings; the second one squeezes the
    // block with the long receiver stall.
    run_phase(32'd0, 90, 1'b0);
    run_phase(32'd1, 200, 1'b1);
    run_phase($urandom_range(2, 200), 90, 1'b0);
    run_phase($urandom_range(1000, 1 << 20), 90, 1'b0);
    run_phase(32'h7FFF_FFFF, 90, 1'b0);
    run_phase($urandom, 90, 1'b0);

    // Widest spread again, then a narrow limit, then a few short sequences.
    run_phase('1, 60, 1'b0);
    run_phase(32'd50, 40, 1'b0);
    send_sequence(4, VAL_FLAT);
    send_sequence(3, VAL_EDGE);

    // Drain: wait for every result, then give stray results time to show.
    stop_offering();
    do @(posedge clk); while (tallies_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d values in %0d sequences under %0d max_spread settings",
             values_sent, sequences_sent, spread_writes);
    $display("checked %0d results, %0d with overflow, %0d mismatches",
             tallies_checked, overflow_tallies, mismatches);
    if (mismatches == 0 && tallies_pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule : tb

// ----- filelist.f -----
hdl/brsc_pkg.sv
hdl/brsc_cell.sv
hdl/brsc_tail.sv
hdl/bounded_range_subarray_counter.sv
bench/brsc_run_checker.sv
bench/tb.sv
